FILE: design/mhpq_pkg.sv
package mhpq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned FillW       = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: design/mhpq_cell.sv
module mhpq_cell (
  input  logic                                 clk_i,
  input  mhpq_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                 valid_i,
  input  logic signed [mhpq_pkg::KeyW-1:0]     new_key_i,
  input  logic                                 prev_place_i,
  input  logic signed [mhpq_pkg::KeyW-1:0]     prev_key_i,
  input  logic signed [mhpq_pkg::KeyW-1:0]     next_key_i,
  output logic                                 place_o,
  output logic signed [mhpq_pkg::KeyW-1:0]     key_o
);
  import mhpq_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;

  // new key belongs at or before this slot
  assign place_o = !valid_i || (new_key_i < key_q);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (prev_place_i) begin
        key_d = prev_key_i;
      end else if (place_o) begin
        key_d = new_key_i;
      end
    end else if (ctrl_i.rem) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

FILE: design/min_heap_priority_queue.sv
// Min priority queue of signed 32-bit keys.
// Request channel: drive opcode_i (0 insert key_in_i, 1 remove minimum)
// and key_in_i with start_i; a request is taken on a rising edge with
// start_i high and busy_o low. busy_o stays low, so a request may be
// issued in every cycle.
// Result channel: done_o is high for exactly one cycle, the cycle after
// the request was taken, with status_o, min_out_o and fill_level_o.
// status_o is ok, full (insert refused) or empty (remove refused);
// min_out_o carries the removed key on a good remove, else zero;
// fill_level_o is the low five bits of the key count after the request.
// Throughput is one request per cycle: the keys sit sorted in a row of
// CAPACITY cells, and every cell compares the new key against its own key
// in the same cycle, then shifts toward or away from its neighbor. The
// minimum is always in the first cell.
// Reset empties the queue; cell contents past the count are don't-care.
// The receiver cannot stall; results must be taken when done_o is high.
module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 opcode_i,
  input  logic signed [mhpq_pkg::KeyW-1:0]     key_in_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [mhpq_pkg::KeyW-1:0]     min_out_o,
  output logic [mhpq_pkg::FillW-1:0]           fill_level_o
);
  import mhpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                   accept;
  logic                   is_remove;
  logic [CntW-1:0]        count_q, count_d;
  logic                   done_q;
  status_e                status_q, status_d;
  logic signed [KeyW-1:0] min_q, min_d;
  logic [FillW-1:0]       fill_q;
  logic [CntW+FillW-1:0]  fill_ext;
  cell_ctrl_t             ctrl;

  logic signed [KeyW-1:0] key [CAPACITY];
  logic [CAPACITY-1:0]    place;
  logic [CAPACITY-1:0]    valid;

  assign busy_o    = 1'b0;
  assign accept    = start_i && !busy_o;
  assign is_remove = (opcode_i == OP_REMOVE);

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    min_d    = '0;
    ctrl     = '0;
    if (accept) begin
      if (!is_remove) begin
        if (count_q == CntW'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          count_d  = count_q + CntW'(1);
        end
      end else begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.rem = 1'b1;
          min_d    = key[0];
          count_d  = count_q - CntW'(1);
        end
      end
    end
  end

  assign fill_ext = {{FillW{1'b0}}, count_d};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   prev_place;
    logic signed [KeyW-1:0] prev_key;
    logic signed [KeyW-1:0] next_key;

    assign valid[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_place = 1'b0;
      assign prev_key   = key_in_i;
    end else begin : g_mid
      assign prev_place = place[i-1];
      assign prev_key   = key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = key[i];
    end else begin : g_inner
      assign next_key = key[i+1];
    end

    mhpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid[i]),
      .new_key_i    (key_in_i),
      .prev_place_i (prev_place),
      .prev_key_i   (prev_key),
      .next_key_i   (next_key),
      .place_o      (place[i]),
      .key_o        (key[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    min_q    <= min_d;
    fill_q   <= fill_ext[FillW-1:0];
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign min_out_o    = min_q;
  assign fill_level_o = fill_q;

`ifndef SYNTHESIS
  logic [CAPACITY-1:0] order_ok;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_order
    if (j == CAPACITY - 1) begin : g_end
      assign order_ok[j] = 1'b1;
    end else begin : g_pair
      assign order_ok[j] = !valid[j+1] || (key[j] <= key[j+1]);
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("key count above capacity");

  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("cell row out of order");

  a_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without result");

  a_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_remove && count_q == '0) |=> (status_o == ST_EMPTY && count_q == '0))
    else $error("remove from empty queue mishandled");

  a_remove_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_remove && count_q > CntW'(1)) |=> (min_out_o <= key[0]))
    else $error("removed key above new minimum");
`endif

endmodule
